@@ hw/rtl/space_time_moments_motion_core_assert.svh @@
// ----------------------------------------------------------------------------
// space-time moments motion core assertion macros
// concurrent checks on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef SPACE_TIME_MOMENTS_MOTION_CORE_ASSERT_SVH
`define SPACE_TIME_MOMENTS_MOTION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define STMM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("stmm assertion failed");
`define STMM_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("stmm forbidden condition");
`else
`define STMM_ASSERT(lbl, prop)
`define STMM_NEVER(lbl, cond)
`endif
`endif

@@ hw/rtl/stmm_pkg.sv @@
// ----------------------------------------------------------------------------
// stmm_pkg
// widths, codes, command types and constant tables of the moments core
// ----------------------------------------------------------------------------
`default_nettype none
package stmm_pkg;
	localparam int COORD_BITS = 12;
	localparam int TIME_BITS  = 8;
	localparam int COUNT_BITS = 20;
	localparam int WIDE_BITS  = (COORD_BITS > TIME_BITS) ? COORD_BITS : TIME_BITS;

	localparam int SX_W  = COORD_BITS + COUNT_BITS;
	localparam int ST_W  = TIME_BITS + COUNT_BITS;
	localparam int SXX_W = 2 * COORD_BITS + COUNT_BITS;
	localparam int STT_W = 2 * TIME_BITS + COUNT_BITS;
	localparam int SXT_W = COORD_BITS + TIME_BITS + COUNT_BITS;

	localparam int MOM_W = 2 * COUNT_BITS + 2 * WIDE_BITS + 2;
	localparam int OP_W  = MOM_W + 1;
	localparam int ACC_W = 2 * OP_W + 2;

	localparam int VEL_W       = 32;
	localparam int QUO_W       = VEL_W + 1;
	localparam int DIV_STEPS   = QUO_W;
	localparam int FRAC_SHIFT  = 17;
	localparam int DIV_W       = MOM_W + QUO_W + 1;

	localparam int ANG_W        = 24;
	localparam int CORDIC_STEPS = 28;
	localparam int CIDX_W       = $clog2(CORDIC_STEPS);
	localparam int CORDIC_W     = 36;
	localparam int NORM_BITS    = 30;
	localparam int ROUND_SHIFT  = 9;
	localparam int ANGLE_LIMIT  = 5898240;

	localparam int MAC_STEPS = 17;
	localparam int STEP_W    = $clog2(MAC_STEPS);
	localparam int ITER_MAX  = (OP_W > DIV_STEPS) ?
		((OP_W > CORDIC_STEPS) ? OP_W : CORDIC_STEPS) :
		((DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS);
	localparam int ITER_W    = $clog2(ITER_MAX);
	localparam int STATUS_W  = 2;

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W - 1){1'b0}}};
	localparam logic signed [CORDIC_W-1:0] ANG_HI = CORDIC_W'(ANGLE_LIMIT);
	localparam logic signed [CORDIC_W-1:0] ANG_LO = -CORDIC_W'(ANGLE_LIMIT);
	localparam logic signed [CORDIC_W-1:0] ROUND_BIAS = CORDIC_W'(1 << (ROUND_SHIFT - 1));

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_POINTS = 2'd1,
		ST_ZERO_VAR  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		SEL_COUNT, SEL_SX, SEL_SY, SEL_ST, SEL_SXX, SEL_SYY, SEL_STT, SEL_SXY,
		SEL_SXT, SEL_SYT, SEL_CXY, SEL_CXT, SEL_CYT, SEL_CTT, SEL_DXY
	} opsel_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_CXX, DST_CYY, DST_CTT, DST_CXY, DST_CXT, DST_CYT, DST_TOP, DST_BOT
	} dst_t;

	typedef struct packed {
		opsel_t sel_a;
		opsel_t sel_b;
		logic   neg;
		logic   clr;
		dst_t   dst;
	} mac_op_t;

	typedef struct packed {
		logic              add_point;
		logic              clear_sums;
		logic              mac_load;
		logic              mac_step;
		logic              mac_store;
		mac_op_t           mop;
		logic              div_load;
		logic              div_step;
		logic              div_store;
		logic              div_sel;
		logic              ang_load;
		logic              ang_shift;
		logic              ang_prep;
		logic              ang_iter;
		logic [CIDX_W-1:0] ang_idx;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic ang_big;
		logic out_busy;
	} sts_t;

	// multiply-accumulate program: centralized moments, then the angle terms
	function automatic mac_op_t mac_prog(input logic [STEP_W-1:0] step);
		mac_op_t op;
		unique case (step)
			STEP_W'(0):  op = '{SEL_COUNT, SEL_SXX, 1'b0, 1'b1, DST_NONE};
			STEP_W'(1):  op = '{SEL_SX,    SEL_SX,  1'b1, 1'b0, DST_CXX};
			STEP_W'(2):  op = '{SEL_COUNT, SEL_SYY, 1'b0, 1'b1, DST_NONE};
			STEP_W'(3):  op = '{SEL_SY,    SEL_SY,  1'b1, 1'b0, DST_CYY};
			STEP_W'(4):  op = '{SEL_COUNT, SEL_STT, 1'b0, 1'b1, DST_NONE};
			STEP_W'(5):  op = '{SEL_ST,    SEL_ST,  1'b1, 1'b0, DST_CTT};
			STEP_W'(6):  op = '{SEL_COUNT, SEL_SXY, 1'b0, 1'b1, DST_NONE};
			STEP_W'(7):  op = '{SEL_SX,    SEL_SY,  1'b1, 1'b0, DST_CXY};
			STEP_W'(8):  op = '{SEL_COUNT, SEL_SXT, 1'b0, 1'b1, DST_NONE};
			STEP_W'(9):  op = '{SEL_SX,    SEL_ST,  1'b1, 1'b0, DST_CXT};
			STEP_W'(10): op = '{SEL_COUNT, SEL_SYT, 1'b0, 1'b1, DST_NONE};
			STEP_W'(11): op = '{SEL_SY,    SEL_ST,  1'b1, 1'b0, DST_CYT};
			STEP_W'(12): op = '{SEL_CXY,   SEL_CTT, 1'b0, 1'b1, DST_NONE};
			STEP_W'(13): op = '{SEL_CXT,   SEL_CYT, 1'b1, 1'b0, DST_TOP};
			STEP_W'(14): op = '{SEL_DXY,   SEL_CTT, 1'b0, 1'b1, DST_NONE};
			STEP_W'(15): op = '{SEL_CYT,   SEL_CYT, 1'b0, 1'b0, DST_NONE};
			STEP_W'(16): op = '{SEL_CXT,   SEL_CXT, 1'b1, 1'b0, DST_BOT};
			default:     op = '{SEL_COUNT, SEL_SXX, 1'b0, 1'b1, DST_NONE};
		endcase
		return op;
	endfunction

	// atan(2^-i) in units of 2^-24 degree
	function automatic logic signed [CORDIC_W-1:0] atan_at(input logic [CIDX_W-1:0] i);
		logic signed [CORDIC_W-1:0] a;
		unique case (i)
			CIDX_W'(0):  a = CORDIC_W'(64'd754974720);
			CIDX_W'(1):  a = CORDIC_W'(64'd445687602);
			CIDX_W'(2):  a = CORDIC_W'(64'd235489088);
			CIDX_W'(3):  a = CORDIC_W'(64'd119537938);
			CIDX_W'(4):  a = CORDIC_W'(64'd60000934);
			CIDX_W'(5):  a = CORDIC_W'(64'd30029717);
			CIDX_W'(6):  a = CORDIC_W'(64'd15018523);
			CIDX_W'(7):  a = CORDIC_W'(64'd7509720);
			CIDX_W'(8):  a = CORDIC_W'(64'd3754917);
			CIDX_W'(9):  a = CORDIC_W'(64'd1877466);
			CIDX_W'(10): a = CORDIC_W'(64'd938734);
			CIDX_W'(11): a = CORDIC_W'(64'd469367);
			CIDX_W'(12): a = CORDIC_W'(64'd234684);
			CIDX_W'(13): a = CORDIC_W'(64'd117342);
			CIDX_W'(14): a = CORDIC_W'(64'd58671);
			CIDX_W'(15): a = CORDIC_W'(64'd29335);
			CIDX_W'(16): a = CORDIC_W'(64'd14668);
			CIDX_W'(17): a = CORDIC_W'(64'd7334);
			CIDX_W'(18): a = CORDIC_W'(64'd3667);
			CIDX_W'(19): a = CORDIC_W'(64'd1833);
			CIDX_W'(20): a = CORDIC_W'(64'd917);
			CIDX_W'(21): a = CORDIC_W'(64'd458);
			CIDX_W'(22): a = CORDIC_W'(64'd229);
			CIDX_W'(23): a = CORDIC_W'(64'd115);
			CIDX_W'(24): a = CORDIC_W'(64'd57);
			CIDX_W'(25): a = CORDIC_W'(64'd29);
			CIDX_W'(26): a = CORDIC_W'(64'd14);
			CIDX_W'(27): a = CORDIC_W'(64'd7);
			default:     a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/stmm_if.sv @@
// ----------------------------------------------------------------------------
// stmm_if
// valid/ready channels for point words and result words
// ----------------------------------------------------------------------------
`default_nettype none
interface stmm_in_if;
	logic                             valid;
	logic                             ready;
	logic [stmm_pkg::COORD_BITS-1:0]  pos_x;
	logic [stmm_pkg::COORD_BITS-1:0]  pos_y;
	logic [stmm_pkg::TIME_BITS-1:0]   time_index;
	logic                             last_point;
	modport source(output valid, pos_x, pos_y, time_index, last_point, input ready);
	modport sink(input valid, pos_x, pos_y, time_index, last_point, output ready);
endinterface

interface stmm_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [stmm_pkg::VEL_W-1:0] velocity_x;
	logic signed [stmm_pkg::VEL_W-1:0] velocity_y;
	logic signed [stmm_pkg::ANG_W-1:0] plane_angle;
	logic [stmm_pkg::COUNT_BITS-1:0]   point_count;
	logic [stmm_pkg::STATUS_W-1:0]     status;
	modport source(output valid, velocity_x, velocity_y, plane_angle, point_count, status,
		input ready);
	modport sink(input valid, velocity_x, velocity_y, plane_angle, point_count, status,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/space_time_moments_motion_core.sv @@
// ----------------------------------------------------------------------------
// space_time_moments_motion_core
// velocities and axis-plane angle from the second-order moments of an object
// ----------------------------------------------------------------------------
// in_ch carries one grid point word (pos_x, pos_y, time_index, last_point);
// out_ch carries one result word per object, given when the point with
// last_point set has been taken.
// points are accepted one per cycle while the core accumulates; the final
// point is added and the core then stops taking points while it computes.
// the computation runs 17 serial multiply-accumulate passes, two divisions,
// a normalize that shifts the angle terms right until both fit in 30 bits,
// and a vectoring cordic before the result word is loaded.
// after reset all sums are zero and no result word is pending.
// the result sits in an output register; while the receiver stalls, the core
// finishes the next object's computation and then waits with its sums held
// until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module space_time_moments_motion_core (
	input  logic        clk,
	input  logic        arst_n,
	stmm_in_if.sink     in_ch,
	stmm_out_if.source  out_ch
);
	stmm_pkg::cmd_t cmd;
	stmm_pkg::sts_t sts;

	stmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_point),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	stmm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pos_x       (in_ch.pos_x),
		.pos_y       (in_ch.pos_y),
		.time_index  (in_ch.time_index),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.velocity_x  (out_ch.velocity_x),
		.velocity_y  (out_ch.velocity_y),
		.plane_angle (out_ch.plane_angle),
		.point_count (out_ch.point_count),
		.status      (out_ch.status)
	);
endmodule
`default_nettype wire

@@ hw/rtl/stmm_mac.sv @@
// ----------------------------------------------------------------------------
// stmm_mac
// bit-serial signed multiply-accumulate, one multiplier bit per step cycle
// ----------------------------------------------------------------------------
`default_nettype none
module stmm_mac (
	input  logic                                clk,
	input  logic                                load,
	input  logic                                clr,
	input  logic                                neg,
	input  logic                                step,
	input  logic signed [stmm_pkg::OP_W-1:0]    op_a,
	input  logic signed [stmm_pkg::OP_W-1:0]    op_b,
	output logic signed [stmm_pkg::ACC_W-1:0]   acc
);
	logic [stmm_pkg::ACC_W-1:0]        ma_q;
	logic [stmm_pkg::OP_W-1:0]         mb_q;
	logic                              sub_q;
	logic signed [stmm_pkg::ACC_W-1:0] acc_q;
	logic [stmm_pkg::OP_W-1:0]         mag_a;
	logic [stmm_pkg::OP_W-1:0]         mag_b;

	assign mag_a = op_a[stmm_pkg::OP_W-1] ? stmm_pkg::OP_W'(-op_a) : stmm_pkg::OP_W'(op_a);
	assign mag_b = op_b[stmm_pkg::OP_W-1] ? stmm_pkg::OP_W'(-op_b) : stmm_pkg::OP_W'(op_b);
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ma_q  <= stmm_pkg::ACC_W'(mag_a);
			mb_q  <= mag_b;
			sub_q <= op_a[stmm_pkg::OP_W-1] ^ op_b[stmm_pkg::OP_W-1] ^ neg;
			if (clr) begin
				acc_q <= '0;
			end
		end else if (step) begin
			if (mb_q[0]) begin
				acc_q <= sub_q ? acc_q - $signed(ma_q) : acc_q + $signed(ma_q);
			end
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/stmm_dp.sv @@
// ----------------------------------------------------------------------------
// stmm_dp
// sums, moment registers, divider, cordic and result register
// ----------------------------------------------------------------------------
`default_nettype none
module stmm_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  stmm_pkg::cmd_t                        cmd,
	output stmm_pkg::sts_t                        sts,
	input  logic [stmm_pkg::COORD_BITS-1:0]       pos_x,
	input  logic [stmm_pkg::COORD_BITS-1:0]       pos_y,
	input  logic [stmm_pkg::TIME_BITS-1:0]        time_index,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [stmm_pkg::VEL_W-1:0]     velocity_x,
	output logic signed [stmm_pkg::VEL_W-1:0]     velocity_y,
	output logic signed [stmm_pkg::ANG_W-1:0]     plane_angle,
	output logic [stmm_pkg::COUNT_BITS-1:0]       point_count,
	output logic [stmm_pkg::STATUS_W-1:0]         status
);
	localparam int CB = stmm_pkg::COORD_BITS;
	localparam int TB = stmm_pkg::TIME_BITS;
	localparam int MW = stmm_pkg::MOM_W;
	localparam int OW = stmm_pkg::OP_W;
	localparam int AW = stmm_pkg::ACC_W;
	localparam int DW = stmm_pkg::DIV_W;
	localparam int QW = stmm_pkg::QUO_W;
	localparam int VW = stmm_pkg::VEL_W;
	localparam int ZW = stmm_pkg::CORDIC_W;
	localparam int NB = stmm_pkg::NORM_BITS;

	logic [stmm_pkg::COUNT_BITS-1:0] count_q;
	logic [stmm_pkg::SX_W-1:0]       sum_x_q, sum_y_q;
	logic [stmm_pkg::ST_W-1:0]       sum_t_q;
	logic [stmm_pkg::SXX_W-1:0]      sum_xx_q, sum_yy_q, sum_xy_q;
	logic [stmm_pkg::STT_W-1:0]      sum_tt_q;
	logic [stmm_pkg::SXT_W-1:0]      sum_xt_q, sum_yt_q;
	logic [2*CB-1:0]                 p_xx, p_yy, p_xy;
	logic [2*TB-1:0]                 p_tt;
	logic [CB+TB-1:0]                p_xt, p_yt;

	logic signed [MW-1:0] cxx_q, cyy_q, ctt_q, cxy_q, cxt_q, cyt_q;
	logic signed [AW-1:0] top_q, bot_q;
	logic signed [OW-1:0] op_a, op_b;
	logic signed [AW-1:0] acc;

	logic signed [MW-1:0] div_c;
	logic [MW-1:0]        div_cm;
	logic                 div_neg_q;
	logic [DW-1:0]        div_r_q, div_d_q;
	logic [QW-1:0]        div_q_q;
	logic [VW-1:0]        vel_res;
	logic [VW-1:0]        vx_q, vy_q;

	logic [AW-1:0]        tm_q, bm_q;
	logic                 top_neg_q, bot_neg_q, zero_q;
	logic signed [ZW-1:0] cx_q, cy_q, cz_q;
	logic signed [ZW-1:0] x0, y0, dx, dy, at, ang_rnd, ang_clip;

	logic                 out_valid_q;
	logic [VW-1:0]        vel_x_q, vel_y_q;
	logic [stmm_pkg::ANG_W-1:0]      ang_q;
	logic [stmm_pkg::COUNT_BITS-1:0] cnt_out_q;
	stmm_pkg::status_t               status_q;
	logic                            ctt_zero;

	// point accumulation
	assign p_xx = pos_x * pos_x;
	assign p_yy = pos_y * pos_y;
	assign p_xy = pos_x * pos_y;
	assign p_tt = time_index * time_index;
	assign p_xt = pos_x * time_index;
	assign p_yt = pos_y * time_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_t_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_tt_q <= '0;
			sum_xy_q <= '0;
			sum_xt_q <= '0;
			sum_yt_q <= '0;
		end else if (cmd.clear_sums) begin
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_t_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_tt_q <= '0;
			sum_xy_q <= '0;
			sum_xt_q <= '0;
			sum_yt_q <= '0;
		end else if (cmd.add_point && (count_q != '1)) begin
			count_q  <= count_q + 1'b1;
			sum_x_q  <= sum_x_q + stmm_pkg::SX_W'(pos_x);
			sum_y_q  <= sum_y_q + stmm_pkg::SX_W'(pos_y);
			sum_t_q  <= sum_t_q + stmm_pkg::ST_W'(time_index);
			sum_xx_q <= sum_xx_q + stmm_pkg::SXX_W'(p_xx);
			sum_yy_q <= sum_yy_q + stmm_pkg::SXX_W'(p_yy);
			sum_tt_q <= sum_tt_q + stmm_pkg::STT_W'(p_tt);
			sum_xy_q <= sum_xy_q + stmm_pkg::SXX_W'(p_xy);
			sum_xt_q <= sum_xt_q + stmm_pkg::SXT_W'(p_xt);
			sum_yt_q <= sum_yt_q + stmm_pkg::SXT_W'(p_yt);
		end
	end

	// operand select
	function automatic logic signed [OW-1:0] pick(input stmm_pkg::opsel_t s);
		logic signed [OW-1:0] v;
		unique case (s)
			stmm_pkg::SEL_COUNT: v = OW'(count_q);
			stmm_pkg::SEL_SX:    v = OW'(sum_x_q);
			stmm_pkg::SEL_SY:    v = OW'(sum_y_q);
			stmm_pkg::SEL_ST:    v = OW'(sum_t_q);
			stmm_pkg::SEL_SXX:   v = OW'(sum_xx_q);
			stmm_pkg::SEL_SYY:   v = OW'(sum_yy_q);
			stmm_pkg::SEL_STT:   v = OW'(sum_tt_q);
			stmm_pkg::SEL_SXY:   v = OW'(sum_xy_q);
			stmm_pkg::SEL_SXT:   v = OW'(sum_xt_q);
			stmm_pkg::SEL_SYT:   v = OW'(sum_yt_q);
			stmm_pkg::SEL_CXY:   v = OW'(cxy_q);
			stmm_pkg::SEL_CXT:   v = OW'(cxt_q);
			stmm_pkg::SEL_CYT:   v = OW'(cyt_q);
			stmm_pkg::SEL_CTT:   v = OW'(ctt_q);
			stmm_pkg::SEL_DXY:   v = OW'(cxx_q) - OW'(cyy_q);
			default:             v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a = pick(cmd.mop.sel_a);
		op_b = pick(cmd.mop.sel_b);
	end

	stmm_mac u_mac (
		.clk  (clk),
		.load (cmd.mac_load),
		.clr  (cmd.mop.clr),
		.neg  (cmd.mop.neg),
		.step (cmd.mac_step),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	always_ff @(posedge clk) begin
		if (cmd.mac_store) begin
			unique case (cmd.mop.dst)
				stmm_pkg::DST_CXX: cxx_q <= acc[MW-1:0];
				stmm_pkg::DST_CYY: cyy_q <= acc[MW-1:0];
				stmm_pkg::DST_CTT: ctt_q <= acc[MW-1:0];
				stmm_pkg::DST_CXY: cxy_q <= acc[MW-1:0];
				stmm_pkg::DST_CXT: cxt_q <= acc[MW-1:0];
				stmm_pkg::DST_CYT: cyt_q <= acc[MW-1:0];
				stmm_pkg::DST_TOP: top_q <= acc <<< 1;
				stmm_pkg::DST_BOT: bot_q <= acc;
				default: ;
			endcase
		end
	end

	// restoring divider for the velocities, rounded by the half-divisor bias
	assign div_c  = cmd.div_sel ? cyt_q : cxt_q;
	assign div_cm = div_c[MW-1] ? MW'(-div_c) : MW'(div_c);

	always_comb begin
		if (!div_neg_q) begin
			vel_res = (div_q_q > QW'(stmm_pkg::VEL_MAX)) ? stmm_pkg::VEL_MAX : div_q_q[VW-1:0];
		end else if (div_q_q[QW-1] || div_q_q[VW-1]) begin
			vel_res = stmm_pkg::VEL_MIN;
		end else begin
			vel_res = -div_q_q[VW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_neg_q <= div_c[MW-1];
			div_r_q   <= (DW'(div_cm) << stmm_pkg::FRAC_SHIFT) + DW'($unsigned(ctt_q));
			div_d_q   <= DW'($unsigned(ctt_q)) << QW;
			div_q_q   <= '0;
		end else if (cmd.div_step) begin
			if (div_r_q >= div_d_q) begin
				div_r_q <= div_r_q - div_d_q;
				div_q_q <= {div_q_q[QW-2:0], 1'b1};
			end else begin
				div_q_q <= {div_q_q[QW-2:0], 1'b0};
			end
			div_d_q <= div_d_q >> 1;
		end
		if (cmd.div_store) begin
			if (cmd.div_sel) begin
				vy_q <= vel_res;
			end else begin
				vx_q <= vel_res;
			end
		end
	end

	// angle: normalize both terms, then vectoring cordic
	assign sts.ang_big = |(tm_q[AW-1:NB] | bm_q[AW-1:NB]);

	always_comb begin
		x0 = ZW'(bm_q[NB-1:0]);
		y0 = ZW'(tm_q[NB-1:0]);
		if (bot_neg_q) begin
			x0 = -x0;
		end
		if (top_neg_q) begin
			y0 = -y0;
		end
	end

	assign dx = cy_q >>> cmd.ang_idx;
	assign dy = cx_q >>> cmd.ang_idx;
	assign at = stmm_pkg::atan_at(cmd.ang_idx);

	always_ff @(posedge clk) begin
		if (cmd.ang_load) begin
			tm_q      <= top_q[AW-1] ? AW'(-top_q) : AW'(top_q);
			bm_q      <= bot_q[AW-1] ? AW'(-bot_q) : AW'(bot_q);
			top_neg_q <= top_q[AW-1];
			bot_neg_q <= bot_q[AW-1];
		end else if (cmd.ang_shift) begin
			tm_q <= tm_q >> 1;
			bm_q <= bm_q >> 1;
		end
		if (cmd.ang_prep) begin
			zero_q <= (x0 == '0) && (y0 == '0);
			if (x0 < 0) begin
				if (y0 >= 0) begin
					cx_q <= y0;
					cy_q <= -x0;
					cz_q <= stmm_pkg::atan_at('0) <<< 1;
				end else begin
					cx_q <= -y0;
					cy_q <= x0;
					cz_q <= -(stmm_pkg::atan_at('0) <<< 1);
				end
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.ang_iter) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end
		end
	end

	always_comb begin
		ang_rnd = (cz_q + stmm_pkg::ROUND_BIAS) >>> stmm_pkg::ROUND_SHIFT;
		if (ang_rnd > stmm_pkg::ANG_HI) begin
			ang_clip = stmm_pkg::ANG_HI;
		end else if (ang_rnd < stmm_pkg::ANG_LO) begin
			ang_clip = stmm_pkg::ANG_LO;
		end else begin
			ang_clip = ang_rnd;
		end
	end

	// result register
	assign ctt_zero = (ctt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			cnt_out_q <= count_q;
			if (count_q == '0) begin
				status_q <= stmm_pkg::ST_NO_POINTS;
				vel_x_q  <= '0;
				vel_y_q  <= '0;
				ang_q    <= '0;
			end else begin
				status_q <= ctt_zero ? stmm_pkg::ST_ZERO_VAR : stmm_pkg::ST_OK;
				vel_x_q  <= ctt_zero ? '0 : vx_q;
				vel_y_q  <= ctt_zero ? '0 : vy_q;
				ang_q    <= zero_q ? '0 : ang_clip[stmm_pkg::ANG_W-1:0];
			end
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign velocity_x   = vel_x_q;
	assign velocity_y   = vel_y_q;
	assign plane_angle  = ang_q;
	assign point_count  = cnt_out_q;
	assign status       = status_q;
endmodule
`default_nettype wire

@@ hw/rtl/stmm_ctrl.sv @@
// ----------------------------------------------------------------------------
// stmm_ctrl
// sequencer: accumulate, moment program, two divisions, angle, result
// ----------------------------------------------------------------------------
`default_nettype none
`include "space_time_moments_motion_core_assert.svh"
module stmm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_last,
	output logic           in_ready,
	output stmm_pkg::cmd_t cmd,
	input  stmm_pkg::sts_t sts
);
	typedef enum logic [3:0] {
		S_ACC, S_MAC_LOAD, S_MAC_RUN, S_MAC_STORE, S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE,
		S_ANG_LOAD, S_ANG_NORM, S_ANG_PREP, S_ANG_ITER, S_OUT
	} state_t;

	state_t                        state_q;
	logic [stmm_pkg::ITER_W-1:0]   iter_q;
	logic [stmm_pkg::STEP_W-1:0]   step_q;
	logic                          sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			iter_q  <= '0;
			step_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_ACC: begin
					if (in_valid && in_last) begin
						step_q  <= '0;
						state_q <= S_MAC_LOAD;
					end
				end
				S_MAC_LOAD: begin
					iter_q  <= stmm_pkg::ITER_W'(stmm_pkg::OP_W - 1);
					state_q <= S_MAC_RUN;
				end
				S_MAC_RUN: begin
					if (iter_q == '0) begin
						state_q <= S_MAC_STORE;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				S_MAC_STORE: begin
					if (step_q == stmm_pkg::STEP_W'(stmm_pkg::MAC_STEPS - 1)) begin
						sel_q   <= 1'b0;
						state_q <= S_DIV_LOAD;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MAC_LOAD;
					end
				end
				S_DIV_LOAD: begin
					iter_q  <= stmm_pkg::ITER_W'(stmm_pkg::DIV_STEPS - 1);
					state_q <= S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (iter_q == '0) begin
						state_q <= S_DIV_STORE;
					end else begin
						iter_q <= iter_q - 1'b1;
					end
				end
				S_DIV_STORE: begin
					if (sel_q) begin
						state_q <= S_ANG_LOAD;
					end else begin
						sel_q   <= 1'b1;
						state_q <= S_DIV_LOAD;
					end
				end
				S_ANG_LOAD: begin
					state_q <= S_ANG_NORM;
				end
				S_ANG_NORM: begin
					if (!sts.ang_big) begin
						state_q <= S_ANG_PREP;
					end
				end
				S_ANG_PREP: begin
					iter_q  <= '0;
					state_q <= S_ANG_ITER;
				end
				S_ANG_ITER: begin
					if (iter_q == stmm_pkg::ITER_W'(stmm_pkg::CORDIC_STEPS - 1)) begin
						state_q <= S_OUT;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!sts.out_busy) begin
						state_q <= S_ACC;
					end
				end
				default: begin
					state_q <= S_ACC;
				end
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.mop        = stmm_pkg::mac_prog(step_q);
		cmd.div_sel    = sel_q;
		cmd.ang_idx    = iter_q[stmm_pkg::CIDX_W-1:0];
		in_ready       = (state_q == S_ACC);
		cmd.add_point  = (state_q == S_ACC) && in_valid;
		cmd.mac_load   = (state_q == S_MAC_LOAD);
		cmd.mac_step   = (state_q == S_MAC_RUN);
		cmd.mac_store  = (state_q == S_MAC_STORE);
		cmd.div_load   = (state_q == S_DIV_LOAD);
		cmd.div_step   = (state_q == S_DIV_RUN);
		cmd.div_store  = (state_q == S_DIV_STORE);
		cmd.ang_load   = (state_q == S_ANG_LOAD);
		cmd.ang_shift  = (state_q == S_ANG_NORM) && sts.ang_big;
		cmd.ang_prep   = (state_q == S_ANG_PREP);
		cmd.ang_iter   = (state_q == S_ANG_ITER);
		cmd.out_load   = (state_q == S_OUT) && !sts.out_busy;
		cmd.clear_sums = (state_q == S_OUT) && !sts.out_busy;
	end

	`STMM_ASSERT(a_out_free, cmd.out_load |-> !sts.out_busy)
	`STMM_NEVER(a_add_clear, cmd.add_point && cmd.clear_sums)
	`STMM_ASSERT(a_prep_norm, cmd.ang_prep |-> !sts.ang_big)
	`STMM_ASSERT(a_last_start, (cmd.add_point && in_last) |=> cmd.mac_load)
endmodule
`default_nettype wire

@@ sim/stmm_moments_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmm_moments_checker
// watches the point and result channels of the moments core, keeps its own
// copy of the exact sums, predicts each result word and compares field by field
// ----------------------------------------------------------------------------
module stmm_moments_checker (
	input  logic clk,
	input  logic arst_n,
	stmm_in_if   in_ch,
	stmm_out_if  out_ch,
	output int   fail_count,
	output int   pending
);
	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic signed [stmm_pkg::VEL_W-1:0] vel_x;
		logic signed [stmm_pkg::VEL_W-1:0] vel_y;
		logic signed [stmm_pkg::ANG_W-1:0] angle;
		logic [stmm_pkg::COUNT_BITS-1:0]   npts;
		logic [stmm_pkg::STATUS_W-1:0]     stat;
	} motion_t;

	localparam longint ARCTAN_STEP [stmm_pkg::CORDIC_STEPS] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};
	localparam logic [stmm_pkg::COUNT_BITS-1:0] COUNT_FULL = '1;

	motion_t motion_expected_q[$];

	logic [stmm_pkg::COUNT_BITS-1:0] n_acc;
	logic [63:0] acc_x, acc_y, acc_t, acc_xx, acc_yy, acc_tt, acc_xy, acc_xt, acc_yt;

	function automatic wide_t widen(input logic [63:0] v);
		return $signed({128'd0, v});
	endfunction

	function automatic wide_t central(input logic [63:0] sab, input logic [63:0] sa,
			input logic [63:0] sb);
		return widen(64'(n_acc)) * widen(sab) - widen(sa) * widen(sb);
	endfunction

	function automatic int bit_len(input logic [191:0] v);
		int n;
		n = 0;
		for (int i = 191; i >= 0; i--)
			if (n == 0 && v[i]) n = i + 1;
		return n;
	endfunction

	function automatic logic [stmm_pkg::VEL_W-1:0] ratio_q16(input wide_t c, input wide_t ctt);
		logic [191:0] num, den, q;
		num = ((c < 0) ? -c : c);
		num = (num << stmm_pkg::FRAC_SHIFT) + ctt;
		den = ctt << 1;
		q = num / den;
		if (c >= 0) return (q > 192'h7FFFFFFF) ? stmm_pkg::VEL_MAX : q[stmm_pkg::VEL_W-1:0];
		if (q >= 192'h80000000) return stmm_pkg::VEL_MIN;
		return -q[stmm_pkg::VEL_W-1:0];
	endfunction

	function automatic logic [stmm_pkg::ANG_W-1:0] half_atan2(input wide_t top, input wide_t bot);
		logic [191:0] tm, bm, ts, bs;
		int l, s;
		longint x, y, z, dx, dy, o, tmp;
		tm = (top < 0) ? -top : top;
		bm = (bot < 0) ? -bot : bot;
		l = (bit_len(tm) > bit_len(bm)) ? bit_len(tm) : bit_len(bm);
		s = (l > stmm_pkg::NORM_BITS) ? l - stmm_pkg::NORM_BITS : 0;
		ts = tm >> s;
		bs = bm >> s;
		y = $signed({32'd0, ts[31:0]});
		x = $signed({32'd0, bs[31:0]});
		if (top < 0) y = -y;
		if (bot < 0) x = -x;
		if (x == 0 && y == 0) return '0;
		z = 0;
		if (x < 0) begin
			tmp = x;
			if (y >= 0) begin
				x = y; y = -tmp; z = 2 * ARCTAN_STEP[0];
			end else begin
				x = -y; y = tmp; z = -2 * ARCTAN_STEP[0];
			end
		end
		for (int i = 0; i < stmm_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += ARCTAN_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ARCTAN_STEP[i];
			end
		end
		o = (z + 256) >>> stmm_pkg::ROUND_SHIFT;
		if (o > stmm_pkg::ANGLE_LIMIT) o = stmm_pkg::ANGLE_LIMIT;
		if (o < -stmm_pkg::ANGLE_LIMIT) o = -stmm_pkg::ANGLE_LIMIT;
		return o[stmm_pkg::ANG_W-1:0];
	endfunction

	function automatic void clear_sums();
		n_acc = '0;
		acc_x = 0; acc_y = 0; acc_t = 0; acc_xx = 0; acc_yy = 0;
		acc_tt = 0; acc_xy = 0; acc_xt = 0; acc_yt = 0;
	endfunction

	function automatic void predict_motion(input logic [63:0] x, input logic [63:0] y,
			input logic [63:0] t, input logic last);
		wide_t cxx, cyy, ctt, cxy, cxt, cyt, top, bot;
		motion_t r;
		if (n_acc != COUNT_FULL) begin
			n_acc++;
			acc_x += x; acc_y += y; acc_t += t;
			acc_xx += x * x; acc_yy += y * y; acc_tt += t * t;
			acc_xy += x * y; acc_xt += x * t; acc_yt += y * t;
		end
		if (!last) return;
		r = '0;
		r.npts = n_acc;
		if (n_acc == 0) begin
			r.stat = stmm_pkg::ST_NO_POINTS;
		end else begin
			cxx = central(acc_xx, acc_x, acc_x);
			cyy = central(acc_yy, acc_y, acc_y);
			ctt = central(acc_tt, acc_t, acc_t);
			cxy = central(acc_xy, acc_x, acc_y);
			cxt = central(acc_xt, acc_x, acc_t);
			cyt = central(acc_yt, acc_y, acc_t);
			top = 2 * (cxy * ctt - cxt * cyt);
			bot = (cxx - cyy) * ctt + cyt * cyt - cxt * cxt;
			if (ctt == 0) begin
				r.stat = stmm_pkg::ST_ZERO_VAR;
			end else begin
				r.stat = stmm_pkg::ST_OK;
				r.vel_x = ratio_q16(cxt, ctt);
				r.vel_y = ratio_q16(cyt, ctt);
			end
			r.angle = half_atan2(top, bot);
		end
		motion_expected_q.push_back(r);
		clear_sums();
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		clear_sums();
	end

	always @(posedge clk) begin
		motion_t e, a;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				predict_motion(64'(in_ch.pos_x), 64'(in_ch.pos_y), 64'(in_ch.time_index),
					in_ch.last_point);
			if (out_ch.valid && out_ch.ready) begin
				a = '{out_ch.velocity_x, out_ch.velocity_y, out_ch.plane_angle,
					out_ch.point_count, out_ch.status};
				if (motion_expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, a);
					fail_count++;
				end else begin
					e = motion_expected_q.pop_front();
					if (a.vel_x !== e.vel_x) begin
						$display("%0t: velocity_x exp %0d got %0d", $time, e.vel_x, a.vel_x);
						fail_count++;
					end
					if (a.vel_y !== e.vel_y) begin
						$display("%0t: velocity_y exp %0d got %0d", $time, e.vel_y, a.vel_y);
						fail_count++;
					end
					if (a.angle !== e.angle) begin
						$display("%0t: plane_angle exp %0d got %0d", $time, e.angle, a.angle);
						fail_count++;
					end
					if (a.npts !== e.npts) begin
						$display("%0t: point_count exp %0d got %0d", $time, e.npts, a.npts);
						fail_count++;
					end
					if (a.stat !== e.stat) begin
						$display("%0t: status exp %0d got %0d", $time, e.stat, a.stat);
						fail_count++;
					end
				end
			end
		end
		pending = motion_expected_q.size();
	end
endmodule

@@ sim/tb_space_time_moments_motion_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_space_time_moments_motion_core
// drives objects of grid points into the moments core under random idling on
// both channels and a long output stall; the checker beside the core predicts
// and compares every result word
// ----------------------------------------------------------------------------
module tb_space_time_moments_motion_core;
	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle;
	int   recv_idle;
	int   phase;
	int   hold_left;
	bit   hold_done;

	stmm_in_if  in_ch ();
	stmm_out_if out_ch ();

	space_time_moments_motion_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	stmm_moments_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	initial begin
		#60_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver side, with one long hold-off in the last random phase
	always @(negedge clk) begin
		if (phase == 2 && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 6000;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_word(input logic [stmm_pkg::COORD_BITS-1:0] x,
			input logic [stmm_pkg::COORD_BITS-1:0] y,
			input logic [stmm_pkg::TIME_BITS-1:0] t, input logic last);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.pos_x      <= x;
		in_ch.pos_y      <= y;
		in_ch.time_index <= t;
		in_ch.last_point <= last;
		#1;
		while (!in_ch.ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	function automatic logic [stmm_pkg::COORD_BITS-1:0] clip(input int v);
		if (v < 0) return '0;
		if (v > (1 << stmm_pkg::COORD_BITS) - 1) return '1;
		return v[stmm_pkg::COORD_BITS-1:0];
	endfunction

	task automatic send_object(output int n);
		int x0, y0, vx, vy, t0, kind, t, nz;
		kind = $urandom_range(99);
		n = ($urandom_range(9) == 0) ? $urandom_range(200, 1) : $urandom_range(20, 1);
		x0 = $urandom_range(4095);
		y0 = $urandom_range(4095);
		vx = $signed($urandom_range(200)) - 100;
		vy = $signed($urandom_range(200)) - 100;
		t0 = $urandom_range(255);
		nz = $urandom_range(8);
		for (int i = 0; i < n; i++) begin
			if (kind < 75) begin
				t = (t0 + i / ($urandom_range(2) + 1)) % 256;
				send_word(clip(x0 + vx * (t - t0) + $signed($urandom_range(2 * nz)) - nz),
					clip(y0 + vy * (t - t0) + $signed($urandom_range(2 * nz)) - nz),
					t[stmm_pkg::TIME_BITS-1:0], i == n - 1);
			end else if (kind < 85) begin
				send_word(stmm_pkg::COORD_BITS'($urandom), stmm_pkg::COORD_BITS'($urandom),
					t0[stmm_pkg::TIME_BITS-1:0], i == n - 1);
			end else begin
				send_word(stmm_pkg::COORD_BITS'($urandom), stmm_pkg::COORD_BITS'($urandom),
					stmm_pkg::TIME_BITS'($urandom), i == n - 1);
			end
		end
	endtask

	initial begin
		int sent;
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		phase = -1;
		hold_left = 0;
		hold_done = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.time_index = '0;
		in_ch.last_point = 1'b0;
		out_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed objects
		send_word(12'd4095, 12'd4095, 8'd255, 1'b1);
		send_word(12'd0, 12'd0, 8'd0, 1'b0);
		send_word(12'd4095, 12'd4095, 8'd255, 1'b1);
		send_word(12'd100, 12'd0, 8'd0, 1'b0);
		send_word(12'd100, 12'd4095, 8'd10, 1'b0);
		send_word(12'd100, 12'd0, 8'd20, 1'b1);
		send_word(12'd4095, 12'd0, 8'd0, 1'b0);
		send_word(12'd0, 12'd4095, 8'd1, 1'b1);
		send_word(12'd0, 12'd0, 8'd7, 1'b0);
		send_word(12'd4095, 12'd100, 8'd7, 1'b0);
		send_word(12'd50, 12'd4095, 8'd7, 1'b1);
		send_word(12'd10, 12'd20, 8'd0, 1'b0);
		send_word(12'd4000, 12'd30, 8'd1, 1'b0);
		send_word(12'd20, 12'd3000, 8'd2, 1'b0);
		send_word(12'd2048, 12'd2048, 8'd128, 1'b1);
		send_word(12'd5, 12'd4090, 8'd0, 1'b0);
		send_word(12'd4090, 12'd5, 8'd255, 1'b1);

		// random objects in three idling phases, about 290 points each
		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
			recv_idle = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
			sent = 0;
			while (sent < 290) begin
				send_object(n);
				sent += n;
			end
		end
		in_ch.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
